// ===== src/adll_pkg.sv =====
// ----------------------------------------------------------------------------
// adll_pkg
// Shared types, constants and helpers for the array doubly linked list.
// ----------------------------------------------------------------------------
package adll_pkg;

	localparam int NUM_IDS = 1024;
	localparam int ID_W    = 10;
	localparam int IDR_W   = ID_W + 1;
	localparam int ADDR_W  = $clog2(NUM_IDS);
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ       = 2'd3;

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		OP_INS_BEFORE,
		OP_INS_AFTER,
		OP_REMOVE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t op;
		id_t target;
		id_t new_id;
	} cmd_t;

	typedef struct packed {
		id_t last_id;
		id_t first_id;
		id_t next_of_target;
		id_t prev_of_target;
	} res_t;

	function automatic logic in_range(id_t id);
		return {1'b0, id} < IDR_W'(NUM_IDS);
	endfunction

endpackage

// ===== src/adll_front.sv =====
// ----------------------------------------------------------------------------
// adll_front
// Accepts items, classifies them into link operations and holds one command.
// Inserts and removes that would change nothing are turned into reads.
// ----------------------------------------------------------------------------
module adll_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     mode,
	input  adll_pkg::id_t  target,
	input  adll_pkg::id_t  new_id,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output adll_pkg::cmd_t cmd
);
	import adll_pkg::*;

	logic cmd_valid_q;
	cmd_t cmd_q;
	cmd_t cmd_d;
	logic ins_ok;

	assign ins_ok = (target != '0) && (new_id != '0) && (target != new_id) &&
	                in_range(target) && in_range(new_id);

	always_comb begin
		cmd_d.target = target;
		cmd_d.new_id = new_id;
		case (mode)
			MODE_INS_BEFORE: cmd_d.op = ins_ok ? OP_INS_BEFORE : OP_READ;
			MODE_INS_AFTER:  cmd_d.op = ins_ok ? OP_INS_AFTER : OP_READ;
			MODE_REMOVE:     cmd_d.op = ((target != '0) && in_range(target)) ?
			                            OP_REMOVE : OP_READ;
			default:         cmd_d.op = OP_READ;
		endcase
	end

	assign in_ready  = en && (!cmd_valid_q || cmd_ready);
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

// ===== src/adll_queue.sv =====
// ----------------------------------------------------------------------------
// adll_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module adll_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  adll_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output adll_pkg::cmd_t pop_cmd
);
	import adll_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;
	localparam int CNT_W = 2;

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/adll_back.sv =====
// ----------------------------------------------------------------------------
// adll_back
// Executes link operations on the two single-port link memories, keeps head
// and tail, and holds the result item in an output register.
// ----------------------------------------------------------------------------
module adll_back (
	input  logic           clk,
	input  logic           arst_n,
	output logic           clearing,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  adll_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output adll_pkg::res_t res
);
	import adll_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LINK,
		ST_WR2
	} state_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		id_t   data;
	} wr_t;

	state_t state_q;
	addr_t  clr_cnt_q;
	cmd_t   cmd_q;
	id_t    head_q;
	id_t    tail_q;
	wr_t    prev_w2_q;
	wr_t    next_w2_q;
	res_t   res_q;
	logic   out_valid_q;
	res_t   out_q;

	id_t    prev_mem [NUM_IDS];
	id_t    next_mem [NUM_IDS];
	id_t    prev_rd_q;
	id_t    next_rd_q;

	logic   prev_we;
	logic   next_we;
	addr_t  prev_addr;
	addr_t  next_addr;
	id_t    prev_wd;
	id_t    next_wd;

	id_t    p;
	id_t    q;
	id_t    t;
	id_t    n;
	wr_t    prev_w1;
	wr_t    next_w1;
	wr_t    prev_w2;
	wr_t    next_w2;
	res_t   res_d;
	id_t    head_d;
	id_t    tail_d;

	assign clearing  = state_q == ST_CLEAR;
	assign cmd_ready = state_q == ST_IDLE;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// plan the link writes from the target's old links
	always_comb begin
		t       = cmd_q.target;
		n       = cmd_q.new_id;
		p       = in_range(t) ? prev_rd_q : '0;
		q       = in_range(t) ? next_rd_q : '0;
		prev_w1 = '0;
		next_w1 = '0;
		prev_w2 = '0;
		next_w2 = '0;
		head_d  = head_q;
		tail_d  = tail_q;
		res_d.prev_of_target = p;
		res_d.next_of_target = q;
		case (cmd_q.op)
			OP_INS_BEFORE: begin
				next_w1 = '{en: p != '0, addr: p[ADDR_W-1:0], data: n};
				next_w2 = '{en: 1'b1, addr: n[ADDR_W-1:0], data: t};
				prev_w1 = '{en: 1'b1, addr: n[ADDR_W-1:0], data: p};
				prev_w2 = '{en: 1'b1, addr: t[ADDR_W-1:0], data: n};
				if (head_q == t) begin
					head_d = n;
				end
				res_d.prev_of_target = n;
				res_d.next_of_target = ((p != '0) && (p == t)) ? n : q;
			end
			OP_INS_AFTER: begin
				prev_w1 = '{en: q != '0, addr: q[ADDR_W-1:0], data: n};
				prev_w2 = '{en: 1'b1, addr: n[ADDR_W-1:0], data: t};
				next_w1 = '{en: 1'b1, addr: n[ADDR_W-1:0], data: q};
				next_w2 = '{en: 1'b1, addr: t[ADDR_W-1:0], data: n};
				if (tail_q == t) begin
					tail_d = n;
				end
				res_d.next_of_target = n;
				res_d.prev_of_target = ((q != '0) && (q == t)) ? n : p;
			end
			OP_REMOVE: begin
				next_w1 = '{en: p != '0, addr: p[ADDR_W-1:0], data: q};
				next_w2 = '{en: 1'b1, addr: t[ADDR_W-1:0], data: '0};
				prev_w1 = '{en: q != '0, addr: q[ADDR_W-1:0], data: p};
				prev_w2 = '{en: 1'b1, addr: t[ADDR_W-1:0], data: '0};
				if (head_q == t) begin
					head_d = q;
				end
				if (tail_q == t) begin
					tail_d = p;
				end
				if (head_d == '0) begin
					tail_d = '0;
				end
				if (tail_d == '0) begin
					head_d = '0;
				end
				res_d.prev_of_target = '0;
				res_d.next_of_target = '0;
			end
			default: begin
			end
		endcase
		res_d.first_id = head_d;
		res_d.last_id  = tail_d;
	end

	always_comb begin
		prev_we   = 1'b0;
		next_we   = 1'b0;
		prev_addr = cmd.target[ADDR_W-1:0];
		next_addr = cmd.target[ADDR_W-1:0];
		prev_wd   = '0;
		next_wd   = '0;
		case (state_q)
			ST_CLEAR: begin
				prev_we   = 1'b1;
				next_we   = 1'b1;
				prev_addr = clr_cnt_q;
				next_addr = clr_cnt_q;
			end
			ST_LINK: begin
				prev_we   = prev_w1.en;
				prev_addr = prev_w1.addr;
				prev_wd   = prev_w1.data;
				next_we   = next_w1.en;
				next_addr = next_w1.addr;
				next_wd   = next_w1.data;
			end
			ST_WR2: begin
				prev_we   = prev_w2_q.en;
				prev_addr = prev_w2_q.addr;
				prev_wd   = prev_w2_q.data;
				next_we   = next_w2_q.en;
				next_addr = next_w2_q.addr;
				next_wd   = next_w2_q.data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_addr] <= prev_wd;
		end
		prev_rd_q <= prev_mem[prev_addr];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_addr] <= next_wd;
		end
		next_rd_q <= next_mem[next_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			cmd_q       <= '0;
			head_q      <= ID_W'(1);
			tail_q      <= ID_W'(1);
			prev_w2_q   <= '0;
			next_w2_q   <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (state_q == ST_WR2 && (!out_valid_q || res_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(NUM_IDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					prev_w2_q <= prev_w2;
					next_w2_q <= next_w2;
					head_q    <= head_d;
					tail_q    <= tail_d;
					res_q     <= res_d;
					state_q   <= ST_WR2;
				end
				ST_WR2: begin
					if (!out_valid_q || res_ready) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/array_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list of ids held in two link memories with head and tail.
// ----------------------------------------------------------------------------
// Each item inserts new_id before or after target, removes target, or reads
// it, and returns one result: target's links and the head and tail after the
// operation. In the back end the target's links are first read from the
// single-port prev and next memories, then each memory takes two writes. A
// two-entry queue sits between the classifying front end and the back end,
// and the result waits in an output register. After reset the back end
// clears both memories, one entry per cycle; no item is accepted until that
// pass ends. Id 0 means none.
module array_doubly_linked_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // mode[1:0], target[11:2], new_id[21:12], zero[23:22]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // prev_of_target[9:0], next_of_target[19:10],
	                              // first_id[29:20], last_id[39:30]
);
	import adll_pkg::*;

	logic clearing;
	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic qb_valid;
	logic qb_ready;
	cmd_t qb_cmd;
	res_t res;

	adll_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (!clearing),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.mode      (s_tdata[1:0]),
		.target    (s_tdata[11:2]),
		.new_id    (s_tdata[21:12]),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	adll_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	adll_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = res;

endmodule

// ===== test/array_doubly_linked_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_doubly_linked_list_test
// Self-checking bench for the array-based doubly linked list.
// ----------------------------------------------------------------------------
// A directed table covers the extreme ids, every operation, ids of zero, self
// inserts, removes of non-members and of head or tail. The random part then
// builds and trims a live list under four idle and stall phases. Emptying the
// list cannot be undone without a reset, so the list is drained and the empty
// list rows run last. Every answer is checked against a local list model or, for typed rows, a fixed expected result.
module array_doubly_linked_list_test;
	import adll_pkg::*;

	typedef struct {
		op_t  op;
		id_t  target;
		id_t  new_id;
		bit   typed;
		res_t want;
	} plan_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	array_doubly_linked_list DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// list model
	id_t prev_link [NUM_IDS];
	id_t next_link [NUM_IDS];
	id_t head_id;
	id_t tail_id;

	// ids believed linked, used to aim well-formed items
	id_t members [$];
	bit  in_list [NUM_IDS];

	res_t      link_answers_due [$];
	plan_row_t directed_plan [$];
	int        bad_answers    = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	res_t      got_answer;
	res_t      want_answer;

	function automatic res_t apply_list_op(op_t op, id_t t, id_t n);
		id_t  p;
		id_t  q;
		res_t r;
		case (op)
			OP_INS_BEFORE: begin
				if (t != 0 && n != 0 && t != n) begin
					p = prev_link[t];
					if (p != 0)
						next_link[p] = n;
					prev_link[n] = prev_link[t];
					next_link[n] = t;
					prev_link[t] = n;
					if (head_id == t)
						head_id = n;
				end
			end
			OP_INS_AFTER: begin
				if (t != 0 && n != 0 && t != n) begin
					q = next_link[t];
					if (q != 0)
						prev_link[q] = n;
					next_link[n] = next_link[t];
					prev_link[n] = t;
					next_link[t] = n;
					if (tail_id == t)
						tail_id = n;
				end
			end
			OP_REMOVE: begin
				if (t != 0) begin
					p = prev_link[t];
					if (p != 0)
						next_link[p] = next_link[t];
					q = next_link[t];
					if (q != 0)
						prev_link[q] = prev_link[t];
					if (head_id == t)
						head_id = next_link[t];
					if (tail_id == t)
						tail_id = prev_link[t];
					if (head_id == 0)
						tail_id = 0;
					if (tail_id == 0)
						head_id = 0;
					prev_link[t] = 0;
					next_link[t] = 0;
				end
			end
			default: ;
		endcase
		r.prev_of_target = prev_link[t];
		r.next_of_target = next_link[t];
		r.first_id       = head_id;
		r.last_id        = tail_id;
		return r;
	endfunction

	function automatic plan_row_t row(op_t op, int t, int n, bit typed = 1'b0,
	                                  int p = 0, int nx = 0, int f = 0, int l = 0);
		plan_row_t r;
		r.op                  = op;
		r.target              = id_t'(t);
		r.new_id              = id_t'(n);
		r.typed               = typed;
		r.want.prev_of_target = id_t'(p);
		r.want.next_of_target = id_t'(nx);
		r.want.first_id       = id_t'(f);
		r.want.last_id        = id_t'(l);
		return r;
	endfunction

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_list_op(input op_t op, input id_t t, input id_t n,
	                            input bit typed, input res_t want);
		res_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, n, t, op};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		r = apply_list_op(op, t, n);
		link_answers_due.push_back(typed ? want : r);
		if ((op == OP_INS_BEFORE || op == OP_INS_AFTER) && t != 0 && n != 0 && t != n &&
		    !in_list[n]) begin
			in_list[n] = 1'b1;
			members.push_back(n);
		end else if (op == OP_REMOVE && t != 0 && in_list[t]) begin
			in_list[t] = 1'b0;
			foreach (members[i])
				if (members[i] == t) begin
					members.delete(i);
					break;
				end
		end
		@(posedge clk);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_answer = res_t'(m_tdata);
			if (link_answers_due.size() == 0) begin
				bad_answers++;
				if (bad_answers <= 10)
					$display("unexpected result: prev %0d next %0d first %0d last %0d",
					         got_answer.prev_of_target, got_answer.next_of_target,
					         got_answer.first_id, got_answer.last_id);
			end else begin
				want_answer = link_answers_due.pop_front();
				if (got_answer != want_answer) begin
					bad_answers++;
					if (bad_answers <= 10)
						$display("mismatch (exp/got): prev %0d/%0d next %0d/%0d first %0d/%0d last %0d/%0d",
						         want_answer.prev_of_target, got_answer.prev_of_target,
						         want_answer.next_of_target, got_answer.next_of_target,
						         want_answer.first_id, got_answer.first_id,
						         want_answer.last_id, got_answer.last_id);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[array_doubly_linked_list] ERROR");
		$finish;
	end

	initial begin
		int   open_count;
		int   k;
		int   drain_guard;
		op_t  op;
		id_t  t;
		id_t  n;

		foreach (prev_link[i]) begin
			prev_link[i] = '0;
			next_link[i] = '0;
			in_list[i]   = 1'b0;
		end
		head_id = 1;
		tail_id = 1;
		in_list[1] = 1'b1;
		members.push_back(1);

		// live list rows
		directed_plan.push_back(row(OP_READ, 1, 0, 1, 0, 0, 1, 1));
		directed_plan.push_back(row(OP_READ, 0, 1023, 1, 0, 0, 1, 1));
		directed_plan.push_back(row(OP_INS_AFTER, 1, 1023));
		directed_plan.push_back(row(OP_INS_BEFORE, 1, 2));
		directed_plan.push_back(row(OP_INS_BEFORE, 1023, 3));
		directed_plan.push_back(row(OP_INS_AFTER, 1023, 4));
		directed_plan.push_back(row(OP_INS_BEFORE, 0, 5));
		directed_plan.push_back(row(OP_INS_AFTER, 1, 0));
		directed_plan.push_back(row(OP_INS_BEFORE, 2, 2));
		directed_plan.push_back(row(OP_READ, 1023, 1023));
		directed_plan.push_back(row(OP_REMOVE, 0, 0));
		directed_plan.push_back(row(OP_REMOVE, 500, 0));
		directed_plan.push_back(row(OP_REMOVE, 1, 0));
		directed_plan.push_back(row(OP_REMOVE, 2, 0));
		directed_plan.push_back(row(OP_REMOVE, 4, 0));
		directed_plan.push_back(row(OP_INS_AFTER, 3, 1));
		open_count = directed_plan.size();
		// empty list rows, after the drain
		directed_plan.push_back(row(OP_READ, 0, 0, 1, 0, 0, 0, 0));
		directed_plan.push_back(row(OP_REMOVE, 1023, 0));
		directed_plan.push_back(row(OP_INS_AFTER, 7, 9));
		directed_plan.push_back(row(OP_INS_BEFORE, 9, 1023));
		directed_plan.push_back(row(OP_INS_AFTER, 7, 9));
		directed_plan.push_back(row(OP_READ, 9, 682));
		directed_plan.push_back(row(OP_READ, 1023, 341));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < open_count; i++)
			send_list_op(directed_plan[i].op, directed_plan[i].target,
			             directed_plan[i].new_id, directed_plan[i].typed,
			             directed_plan[i].want);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			for (int j = 0; j < 435; j++) begin
				if ($urandom_range(99) < 12) begin
					op = op_t'($urandom_range(3));
					t  = id_t'($urandom);
					n  = id_t'($urandom);
				end else begin
					k = $urandom_range(99);
					if (members.size() < 3)
						k = 0;
					else if (members.size() > 40)
						k = k / 2 + 50;
					t = (members.size() == 0) ? head_id :
					    members[$urandom_range(members.size() - 1)];
					n = id_t'($urandom);
					if (k < 40) begin
						op = (k < 20) ? OP_INS_BEFORE : OP_INS_AFTER;
						do
							n = id_t'($urandom_range(NUM_IDS - 1, 1));
						while (in_list[n]);
					end else if (k < 70)
						op = OP_REMOVE;
					else
						op = OP_READ;
				end
				// keep the list alive: an empty list never regains a head
				if (op == OP_REMOVE && t != 0 && ((head_id == t && next_link[t] == 0) ||
				    (tail_id == t && prev_link[t] == 0)))
					op = OP_READ;
				send_list_op(op, t, n, 1'b0, '0);
			end
		end

		drain_guard = 0;
		while (head_id != 0 && drain_guard < 1100) begin
			send_list_op(OP_REMOVE, head_id, id_t'($urandom), 1'b0, '0);
			drain_guard++;
		end

		for (int i = open_count; i < directed_plan.size(); i++)
			send_list_op(directed_plan[i].op, directed_plan[i].target,
			             directed_plan[i].new_id, directed_plan[i].typed,
			             directed_plan[i].want);
		s_tvalid <= 1'b0;

		while (link_answers_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (bad_answers == 0 && link_answers_due.size() == 0)
			$display("[array_doubly_linked_list] OK");
		else
			$display("[array_doubly_linked_list] ERROR");
		$finish;
	end

endmodule
